// ----- hw/rtl/sjhc_pkg.sv -----
// Package with the payload types, activity codes and constants of the jog and homing controller.
package sjhc_pkg;

   localparam int COUNT_W = 17;
   localparam int POS_W   = 32;
   localparam int MULT_W  = 10;

   localparam logic [MULT_W-1:0] JOG_SMALL   = 10'd10;
   localparam logic [MULT_W-1:0] JOG_MEDIUM  = 10'd100;
   localparam logic [MULT_W-1:0] JOG_LARGE   = 10'd1000;
   localparam logic [MULT_W-1:0] HOME_PULSES = 10'd300;

   localparam logic [1:0] MODE_HOME   = 2'd0;
   localparam logic [1:0] MODE_SMALL  = 2'd1;
   localparam logic [1:0] MODE_MEDIUM = 2'd2;

   localparam logic CSR_GEAR_RATIO = 1'b0;
   localparam logic CSR_LOCKOUT    = 1'b1;

   localparam logic [6:0]  GEAR_RESET    = 7'd10;
   localparam logic [15:0] LOCKOUT_RESET = 16'd625;

   typedef enum logic [5:0] {
      ACT_IDLE   = 6'b000001,
      ACT_PLUS   = 6'b000010,
      ACT_MINUS  = 6'b000100,
      ACT_SEEK   = 6'b001000,
      ACT_BACK   = 6'b010000,
      ACT_RETURN = 6'b100000
   } act_type;

   typedef struct packed {
      logic plus_pressed;
      logic minus_pressed;
      logic select_pressed;
      logic home_active;
   } req_type;

   typedef struct packed {
      logic                    step_level;
      logic                    direction;
      logic [1:0]              mode;
      logic                    busy_res;
      logic signed [POS_W-1:0] position_steps;
      logic                    at_home;
   } rsp_type;

endpackage

// ----- hw/rtl/stepper_jog_homing_controller_core.sv -----
// Stepper jog and homing controller: one tick request in, one step and status response out.
// An accepted request's response is captured in the output register as the request is taken.
// Throughput: one request per cycle; the single tick update sits between the state registers
// and the output register, and a request is taken whenever the output register is empty or
// being taken in the same cycle.
// Reset (synchronous, active high) clears mode, activity, counters and position, and loads
// the gear ratio with 10 and the select lockout with 625 ticks.
module stepper_jog_homing_controller_core
   import sjhc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   // Configuration registers.
   logic [6:0]  gear_ff;
   logic [15:0] lockout_cfg_ff;

   // Controller state.
   logic [1:0]               mode_ff, mode_in;
   act_type                  act_ff, act_in;
   logic [COUNT_W-1:0]       pulses_ff, pulses_in;
   logic                     phase_ff, phase_in;
   logic signed [POS_W-1:0]  pos_ff, pos_in;
   logic [15:0]              lock_ff, lock_in;

   // Output register.
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   logic req_accept;

   // The output register frees up when it is empty or its response is being taken.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // A gear ratio of zero behaves as one.
   logic [6:0]          gear_eff;
   logic [MULT_W-1:0]   jog_mult;
   logic [COUNT_W-1:0]  jog_count;
   logic [COUNT_W-1:0]  home_count;

   assign gear_eff = (gear_ff == 7'd0) ? 7'd1 : gear_ff;

   always_comb begin
      unique case (mode_ff)
         MODE_SMALL:  jog_mult = JOG_SMALL;
         MODE_MEDIUM: jog_mult = JOG_MEDIUM;
         default:     jog_mult = JOG_LARGE;
      endcase
   end

   // Both products stay below 2^17 for gear ratios up to 127.
   assign jog_count  = COUNT_W'(jog_mult) * COUNT_W'(gear_eff);
   assign home_count = COUNT_W'(HOME_PULSES) * COUNT_W'(gear_eff);

   // One tick of the controller.
   logic                sel_ok;
   logic                plus, minus, sel, home;
   logic [COUNT_W-1:0]  pulses_dec;
   logic                step, dir, busy;
   act_type             act_mid;
   logic [COUNT_W-1:0]  pulses_mid;

   assign plus  = req_data.plus_pressed;
   assign minus = req_data.minus_pressed;
   assign sel   = req_data.select_pressed;
   assign home  = req_data.home_active;

   always_comb begin
      mode_in   = mode_ff;
      act_mid   = act_ff;
      pulses_mid = pulses_ff;
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      step      = 1'b0;
      dir       = 1'b0;
      busy      = 1'b0;
      pulses_dec = pulses_ff;

      sel_ok  = (act_ff == ACT_IDLE) && sel && (lock_ff == 16'd0);
      lock_in = (lock_ff != 16'd0) ? lock_ff - 16'd1 : lock_ff;

      // Idle tick: a select press changes the mode, otherwise a button may start a move.
      if (sel_ok) begin
         mode_in = mode_ff + 2'd1;
         lock_in = lockout_cfg_ff;
      end else if (act_ff == ACT_IDLE) begin
         phase_in = 1'b0;
         if (mode_ff == MODE_HOME) begin
            if (plus) begin
               act_mid = ACT_SEEK;
            end else if (minus) begin
               pos_in = '0;
            end
         end else if (plus) begin
            act_mid    = ACT_PLUS;
            pulses_mid = jog_count;
         end else if (minus && !home) begin
            act_mid    = ACT_MINUS;
            pulses_mid = jog_count;
         end
      end

      act_in    = act_mid;
      pulses_in = pulses_mid;

      if (act_mid != ACT_IDLE) begin
         busy = 1'b1;
         if (!phase_in) begin
            // High half of a pulse; the home switch ends the seek here.
            if (act_mid == ACT_SEEK && home) begin
               act_in    = ACT_BACK;
               pulses_in = home_count;
            end
            dir      = !(act_in == ACT_MINUS || act_in == ACT_BACK);
            step     = 1'b1;
            phase_in = 1'b1;
         end else begin
            // Low half of a pulse completes it.
            dir      = !(act_mid == ACT_MINUS || act_mid == ACT_BACK);
            phase_in = 1'b0;
            if (act_mid != ACT_SEEK && pulses_mid != '0) begin
               pulses_dec = pulses_mid - COUNT_W'(1);
            end else begin
               pulses_dec = pulses_mid;
            end
            pulses_in = pulses_dec;
            unique case (act_mid)
               ACT_PLUS: begin
                  if (pos_in != {1'b0, {(POS_W-1){1'b1}}}) begin
                     pos_in = pos_in + 32'sd1;
                  end
                  if (pulses_dec == '0) begin
                     act_in = ACT_IDLE;
                  end
               end
               ACT_MINUS: begin
                  if (pos_in != {1'b1, {(POS_W-1){1'b0}}}) begin
                     pos_in = pos_in - 32'sd1;
                  end
                  if (pulses_dec == '0 || home) begin
                     act_in = ACT_IDLE;
                  end
               end
               ACT_BACK: begin
                  if (pulses_dec == '0) begin
                     act_in    = ACT_RETURN;
                     pulses_in = home_count;
                  end
               end
               ACT_RETURN: begin
                  if (pulses_dec == '0) begin
                     pos_in = '0;
                     act_in = ACT_IDLE;
                  end
               end
               default: begin
                  act_in = act_mid;
               end
            endcase
         end
      end

      rsp_data_in.step_level     = step;
      rsp_data_in.direction      = dir;
      rsp_data_in.mode           = mode_in;
      rsp_data_in.busy_res       = busy;
      rsp_data_in.position_steps = pos_in;
      rsp_data_in.at_home        = home;
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         gear_ff        <= GEAR_RESET;
         lockout_cfg_ff <= LOCKOUT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GEAR_RATIO: gear_ff        <= csr_wdata[6:0];
            CSR_LOCKOUT:    lockout_cfg_ff <= csr_wdata;
            default:        gear_ff        <= gear_ff;
         endcase
      end
   end

   // State update, one tick per accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= '0;
         act_ff    <= ACT_IDLE;
         pulses_ff <= '0;
         phase_ff  <= 1'b0;
         pos_ff    <= '0;
         lock_ff   <= '0;
      end else if (req_accept) begin
         mode_ff   <= mode_in;
         act_ff    <= act_in;
         pulses_ff <= pulses_in;
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         lock_ff   <= lock_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // A step pulse is only ever driven as part of a move.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.step_level) |-> rsp_data_ff.busy_res)
      else $error("step pulse outside a move");

   // The tick after a high half always drives the step line low.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && phase_ff) |=> !rsp_data_ff.step_level)
      else $error("two high step ticks in a row");

   // While the select lockout runs, the mode cannot change.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && lock_ff != 16'd0) |=> $stable(mode_ff))
      else $error("mode changed during select lockout");

   // An idle controller never sits in the middle of a pulse.
   assert property (@(posedge clock) disable iff (reset)
      (act_ff == ACT_IDLE) |-> !phase_ff)
      else $error("idle with a pending low half");

   // Without a move the direction line rests low.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.busy_res) |-> !rsp_data_ff.direction)
      else $error("direction high while idle");

endmodule

// ----- tb/stepper_jog_homing_controller_core_tb.sv -----
// Self-checking testbench for the stepper jog and homing controller core.
module stepper_jog_homing_controller_core_tb
   import sjhc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Generous ceiling: a few thousand ticks, each of which may meet the longest
   // sender gap and receiver stall, taken several times over.
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int TICK_CAP    = 4_000;

   localparam logic signed [POS_W-1:0] POS_TOP    = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_BOTTOM = {1'b1, {(POS_W-1){1'b0}}};

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;

   // Configuration as the testbench believes the block holds it.
   logic [6:0]  cfg_gear;
   logic [15:0] cfg_lockout;

   // Controller state mirrored tick by tick.
   logic [1:0]                m_mode;
   act_type                   m_act;
   logic [COUNT_W-1:0]        m_left;
   logic                      m_phase;
   logic signed [POS_W-1:0]   m_pos;
   logic [15:0]               m_lock;

   // Status words owed by the block, oldest first.
   rsp_type status_due[$];
   rsp_type status_want;

   int  fail_count;
   int  tick_count;
   int  cycle_count;
   int  hold_req;
   int  hold_left;
   int  burst_left;
   bit  idle_on;

   stepper_jog_homing_controller_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advances the mirrored controller by one tick and returns the status word
   // the block must produce for it.
   function automatic rsp_type advance_tick(input req_type r);
      rsp_type res;
      int      gear_eff;
      int      mult;
      logic    sel_ok;
      res = '0;
      gear_eff = (cfg_gear == 7'd0) ? 1 : int'(cfg_gear);
      // Select only counts while idle and after the lockout has run out.
      sel_ok = (m_act == ACT_IDLE) && r.select_pressed && (m_lock == 16'd0);
      if (m_lock != 16'd0) m_lock = m_lock - 16'd1;
      if (sel_ok) begin
         m_mode = m_mode + 2'd1;
         m_lock = cfg_lockout;
      end else if (m_act == ACT_IDLE) begin
         case (m_mode)
            MODE_SMALL: begin
               mult = int'(JOG_SMALL);
            end
            MODE_MEDIUM: begin
               mult = int'(JOG_MEDIUM);
            end
            default: begin
               mult = int'(JOG_LARGE);
            end
         endcase
         m_phase = 1'b0;
         if (m_mode == MODE_HOME) begin
            if (r.plus_pressed) m_act = ACT_SEEK;
            else if (r.minus_pressed) m_pos = '0;
         end else if (r.plus_pressed) begin
            m_act  = ACT_PLUS;
            m_left = COUNT_W'(mult * gear_eff);
         end else if (r.minus_pressed && !r.home_active) begin
            m_act  = ACT_MINUS;
            m_left = COUNT_W'(mult * gear_eff);
         end
      end

      if (m_act != ACT_IDLE) begin
         res.busy_res = 1'b1;
         if (!m_phase) begin
            // The home switch ends the seek only at the start of a pulse.
            if (m_act == ACT_SEEK && r.home_active) begin
               m_act  = ACT_BACK;
               m_left = COUNT_W'(int'(HOME_PULSES) * gear_eff);
            end
            res.direction  = !(m_act == ACT_MINUS || m_act == ACT_BACK);
            res.step_level = 1'b1;
            m_phase = 1'b1;
         end else begin
            res.direction  = !(m_act == ACT_MINUS || m_act == ACT_BACK);
            res.step_level = 1'b0;
            m_phase = 1'b0;
            if (m_act != ACT_SEEK && m_left != '0) m_left = m_left - COUNT_W'(1);
            case (m_act)
               ACT_PLUS: begin
                  if (m_pos != POS_TOP) m_pos = m_pos + 1;
                  if (m_left == '0) m_act = ACT_IDLE;
               end
               ACT_MINUS: begin
                  if (m_pos != POS_BOTTOM) m_pos = m_pos - 1;
                  if (m_left == '0 || r.home_active) m_act = ACT_IDLE;
               end
               ACT_BACK: begin
                  if (m_left == '0) begin
                     m_act  = ACT_RETURN;
                     m_left = COUNT_W'(int'(HOME_PULSES) * gear_eff);
                  end
               end
               ACT_RETURN: begin
                  if (m_left == '0) begin
                     m_pos = '0;
                     m_act = ACT_IDLE;
                  end
               end
               default: begin
               end
            endcase
         end
      end
      res.mode           = m_mode;
      res.position_steps = m_pos;
      res.at_home        = r.home_active;
      return res;
   endfunction

   // Random operator input. Plus is never pressed in home or large mode, since homing
   // and a large jog each run for thousands of ticks; those are left to the directed
   // tests. Medium jogs are rare for the same reason.
   function automatic req_type operator_buttons();
      req_type r;
      r.home_active    = ($urandom_range(0, 4) == 0);
      r.select_pressed = ($urandom_range(0, 3) == 0);
      r.minus_pressed  = ($urandom_range(0, 2) == 0);
      case (m_mode)
         MODE_SMALL: begin
            r.plus_pressed = ($urandom_range(0, 2) == 0);
         end
         MODE_MEDIUM: begin
            r.plus_pressed = ($urandom_range(0, 29) == 0);
         end
         default: begin
            r.plus_pressed = 1'b0;
         end
      endcase
      return r;
   endfunction

   // Offers one tick request and waits for its handshake; the expected status is
   // computed at the edge that accepts it. Valid is left high for a following request.
   task automatic send_tick(input req_type r);
      if (idle_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      status_due.push_back(advance_tick(r));
      tick_count++;
   endtask

   task automatic press(input logic p, input logic m, input logic s, input logic h);
      req_type r;
      r.plus_pressed   = p;
      r.minus_pressed  = m;
      r.select_pressed = s;
      r.home_active    = h;
      send_tick(r);
   endtask

   // Drops valid and waits until every owed status word has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (status_due.size() != 0);
   endtask

   // Keeps ticking with noise on the buttons until the running move is over.
   task automatic finish_move(input bit home_allowed);
      req_type r;
      while (m_act != ACT_IDLE) begin
         r = operator_buttons();
         if (!home_allowed) r.home_active = 1'b0;
         send_tick(r);
      end
   endtask

   // Writes both registers while nothing is in flight.
   task automatic set_config(input logic [15:0] gear_word, input logic [15:0] lockout_word);
      drain();
      csr_we    <= 1'b1;
      csr_index <= CSR_GEAR_RATIO;
      csr_wdata <= gear_word;
      @(posedge clock);
      cfg_gear  = gear_word[6:0];
      csr_index <= CSR_LOCKOUT;
      csr_wdata <= lockout_word;
      @(posedge clock);
      cfg_lockout = lockout_word;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Reset defaults: gear 10 and a 625 tick lockout. Select with every other button
   // wins and starts nothing; a second select inside the lockout is ignored, and
   // minus is refused at home.
   task automatic test_reset_values();
      press(1'b0, 1'b0, 1'b0, 1'b0);
      press(1'b0, 1'b0, 1'b0, 1'b1);
      press(1'b0, 1'b1, 1'b0, 1'b0);
      press(1'b1, 1'b1, 1'b1, 1'b0);
      press(1'b0, 1'b1, 1'b1, 1'b1);
      press(1'b0, 1'b0, 1'b1, 1'b0);
   endtask

   // Holds select until the 625 tick lockout from reset runs out. The register is
   // already zero, so the press that gets through reloads a zero lockout.
   task automatic test_select_lockout();
      logic m;
      set_config(16'd1, 16'd0);
      while (m_mode == MODE_SMALL) begin
         m = 1'($urandom_range(0, 1));
         press(1'b0, m, 1'b1, m | ($urandom_range(0, 1) == 1));
      end
   endtask

   task automatic test_jog_cases();
      // Zero lockout: select is taken on every idle tick, wrapping through mode 0.
      repeat (3) press(1'b0, 1'b0, 1'b1, 1'b0);
      // Plus beats minus; buttons during the jog are ignored.
      press(1'b1, 1'b1, 1'b0, 1'b0);
      finish_move(1'b1);
      press(1'b0, 1'b1, 1'b0, 1'b1);
      // Minus jog cut short by the home switch on a low tick.
      press(1'b0, 1'b1, 1'b0, 1'b0);
      press(1'b0, 1'b0, 1'b0, 1'b0);
      press(1'b0, 1'b0, 1'b0, 1'b0);
      press(1'b0, 1'b0, 1'b0, 1'b1);
      press(1'b0, 1'b0, 1'b0, 1'b0);
      // A full minus jog drives the position negative.
      press(1'b0, 1'b1, 1'b0, 1'b0);
      finish_move(1'b0);
      // Gear ratio zero behaves as one.
      set_config(16'd0, 16'd0);
      press(1'b1, 1'b0, 1'b0, 1'b0);
      finish_move(1'b1);
      // A gear ratio of 100, stopped early at home.
      set_config(16'd100, 16'd0);
      press(1'b0, 1'b1, 1'b0, 1'b0);
      press(1'b0, 1'b0, 1'b0, 1'b0);
      press(1'b0, 1'b0, 1'b0, 1'b0);
      press(1'b0, 1'b0, 1'b0, 1'b1);
      // Back to mode 0, where minus clears the position.
      repeat (3) press(1'b0, 1'b0, 1'b1, 1'b0);
      press(1'b0, 1'b1, 1'b0, 1'b0);
   endtask

   // Full homing pass from a nonzero position: seek, back off, return, zero.
   task automatic test_homing();
      set_config(16'd1, 16'd0);
      press(1'b0, 1'b0, 1'b1, 1'b0);
      press(1'b1, 1'b0, 1'b0, 1'b0);
      finish_move(1'b1);
      repeat (3) press(1'b0, 1'b0, 1'b1, 1'b0);
      press(1'b1, 1'b0, 1'b0, 1'b0);
      repeat (4) press(1'b0, 1'b0, 1'b0, 1'b0);
      while (m_act == ACT_SEEK) press(1'b0, 1'b0, 1'b0, ($urandom_range(0, 3) == 0));
      finish_move(1'b1);
   endtask

   // The receiver holds off for a long stretch while requests keep coming, so the
   // block fills and stalls its input; then the sender waits for every response.
   task automatic test_backpressure();
      hold_req = 80;
      repeat (40) send_tick(operator_buttons());
      finish_move(1'b1);
      drain();
   endtask

   // Phases of random operator input, each under its own gear and lockout.
   task automatic test_random_ticks();
      int          decisions;
      int          phase_decisions;
      logic [15:0] gear_word;
      logic [15:0] lockout_word;
      decisions = 0;
      while (decisions < 100 && tick_count < TICK_CAP) begin
         case ($urandom_range(0, 6))
            0: begin
               gear_word = 16'd0;
            end
            4: begin
               gear_word = 16'd2;
            end
            5: begin
               gear_word = 16'd3;
            end
            6: begin
               gear_word = 16'($urandom_range(1, 5));
            end
            default: begin
               gear_word = 16'd1;
            end
         endcase
         if ($urandom_range(0, 3) == 0) lockout_word = 16'($urandom_range(4, 40));
         else lockout_word = 16'($urandom_range(0, 3));
         set_config(gear_word, lockout_word);
         phase_decisions = 0;
         while (phase_decisions < 20 && tick_count < TICK_CAP) begin
            if (m_act == ACT_IDLE) phase_decisions++;
            send_tick(operator_buttons());
         end
         decisions += phase_decisions;
         finish_move(1'b1);
      end
   endtask

   // Last part, with no idling: all-ones register writes (gear masks to 127) and
   // the longest lockout, which then swallows every further select.
   task automatic test_long_lockout();
      idle_on = 1'b0;
      set_config(16'hFFFF, 16'hFFFF);
      press(1'b0, 1'b0, 1'b1, 1'b0);
      repeat (6) press(1'b0, 1'b0, 1'b1, ($urandom_range(0, 1) == 1));
      press(1'b0, 1'b1, 1'b1, 1'b1);
      press(1'b0, 1'b1, 1'b0, 1'b0);
      finish_move(1'b1);
      repeat (4) press(1'b0, 1'b0, 1'b1, 1'b0);
   endtask

   // Receiver: random stall bursts, plus a long hold-off counted down here when a
   // test asks for one.
   initial begin
      rsp_stall  = 1'b0;
      hold_left  = 0;
      burst_left = 0;
      forever begin
         @(posedge clock);
         if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            burst_left = $urandom_range(0, 14);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
         fail_count++;
      end
   endtask

   // Every accepted response is matched against the oldest owed status word.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (status_due.size() == 0) begin
            $error("response with no request outstanding");
            fail_count++;
         end else begin
            status_want = status_due.pop_front();
            check_field("step_level", 32'(status_want.step_level),
                        32'(rsp_data.step_level));
            check_field("direction", 32'(status_want.direction),
                        32'(rsp_data.direction));
            check_field("mode", 32'(status_want.mode), 32'(rsp_data.mode));
            check_field("busy_res", 32'(status_want.busy_res),
                        32'(rsp_data.busy_res));
            check_field("position_steps", status_want.position_steps,
                        rsp_data.position_steps);
            check_field("at_home", 32'(status_want.at_home), 32'(rsp_data.at_home));
         end
      end
   end

   // Watchdog.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      csr_we     = 1'b0;
      csr_index  = CSR_GEAR_RATIO;
      csr_wdata  = '0;
      idle_on    = 1'b1;
      hold_req   = 0;
      fail_count = 0;
      tick_count = 0;
      cfg_gear    = GEAR_RESET;
      cfg_lockout = LOCKOUT_RESET;
      m_mode  = MODE_HOME;
      m_act   = ACT_IDLE;
      m_left  = '0;
      m_phase = 1'b0;
      m_pos   = '0;
      m_lock  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_select_lockout();
      test_jog_cases();
      test_homing();
      test_backpressure();
      test_random_ticks();
      test_long_lockout();

      drain();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
